>>> hw/rtl/triangle_pixel_texture_coord_assert.svh
// Assertion macros used by the checker file.
`ifndef TRIANGLE_PIXEL_TEXTURE_COORD_ASSERT_SVH
`define TRIANGLE_PIXEL_TEXTURE_COORD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tptc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tptc assertion failed");

`endif

>>> hw/rtl/tptc_pkg.sv
package tptc_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 512;
  localparam int unsigned SCREEN_HEIGHT_DEF = 512;

  localparam int unsigned PIX_W   = 9;
  localparam int unsigned VTX_W   = 16;
  localparam int unsigned CRD_W   = 20;
  localparam int unsigned GD_W    = 21;
  localparam int unsigned FD_W    = 17;
  localparam int unsigned PRD_W   = GD_W + FD_W;
  localparam int unsigned EDG_W   = PRD_W + 1;
  localparam int unsigned IZ_W    = 24;
  localparam int unsigned UZ_W    = 20;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned TEX_W   = 13;
  localparam int unsigned SCL_W   = TEX_W + 4;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned PART_W  = HALF_W + SCL_W;
  localparam int unsigned NUM_W   = SUM_W + SCL_W;
  localparam int unsigned DIV_STAGES = TEX_W;
  localparam int unsigned FRONT_STAGES = 8;
  localparam int unsigned META_STAGES  = FRONT_STAGES + DIV_STAGES;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Edge k runs from vertex EDGE_FROM[k] to vertex EDGE_TO[k].
  localparam int unsigned EDGE_FROM [3] = '{2, 0, 1};
  localparam int unsigned EDGE_TO   [3] = '{1, 2, 0};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0_POS  = 3'd0,
    REG_V0_ATTR = 3'd1,
    REG_V1_POS  = 3'd2,
    REG_V1_ATTR = 3'd3,
    REG_V2_POS  = 3'd4,
    REG_V2_ATTR = 3'd5,
    REG_TEX_SIZE = 3'd6,
    REG_DRAW_MODE = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_COVER = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_PERSP = 2'd2
  } draw_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             cov;
    logic             zero_u;
    logic             sat_u;
    logic             zero_v;
    logic             sat_v;
  } meta_t;

endpackage

>>> hw/rtl/tptc_div.sv
module tptc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tptc_pkg::NUM_W-1:0]    num_i,
  input  logic [tptc_pkg::SUM_W-1:0]    den_i,
  output logic [tptc_pkg::TEX_W-1:0]    quo_o
);
  import tptc_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_STAGES-1];
  logic [SUM_W-1:0] den_r [DIV_STAGES-1];
  logic [TEX_W-1:0] quo_r [DIV_STAGES];

  // One quotient bit per stage, most significant first; the remainder
  // enters below den << TEX_W, so TEX_W bits cover the quotient.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int unsigned B = DIV_STAGES - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [SUM_W-1:0] den_in;
    logic [TEX_W-1:0] quo_in;
    logic [NUM_W-1:0] trial;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = NUM_W'(den_in) << B;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= {quo_in[TEX_W-2:0], take};
      end
    end

    // The last stage only needs its quotient bit.
    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? rem_in - trial : rem_in;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

>>> hw/rtl/triangle_pixel_texture_coord.sv
// Throughput: one pixel per cycle; the 22 register stages move together and
// hold as one while a result waits on out_tready, so nothing is lost or repeated.
// The texture divide is 13 pipelined restoring stages, one quotient bit each.
// Reset (rst_n low, synchronous) clears all stage valid bits and every
// configuration register to zero.
module triangle_pixel_texture_coord #(
  parameter int unsigned SCREEN_HEIGHT = tptc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // pixel_column, pixel_row
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,  // covered, texel_x, texel_y,
                                                       // out_column, out_row
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tptc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tptc_pkg::*;

  localparam int unsigned PY_BASE = SCREEN_HEIGHT * 16 + 8;

  // Configuration registers.
  logic [31:0]       pos_r  [3];
  logic [63:0]       attr_r [3];
  logic [25:0]       tex_size_r;
  logic [1:0]        mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i]  <= '0;
        attr_r[i] <= '0;
      end
      tex_size_r <= '0;
      mode_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_V0_POS:    pos_r[0]   <= cfg_data[31:0];
        REG_V0_ATTR:   attr_r[0]  <= cfg_data;
        REG_V1_POS:    pos_r[1]   <= cfg_data[31:0];
        REG_V1_ATTR:   attr_r[1]  <= cfg_data;
        REG_V2_POS:    pos_r[2]   <= cfg_data[31:0];
        REG_V2_ATTR:   attr_r[2]  <= cfg_data;
        REG_TEX_SIZE:  tex_size_r <= cfg_data[25:0];
        REG_DRAW_MODE: mode_r     <= cfg_data[1:0];
      endcase
    end
  end

  logic [TEX_W-1:0] size_u, size_v;
  assign size_u = tex_size_r[12:0];
  assign size_v = tex_size_r[25:13];

  // Pipeline control: every stage advances when the output slot is free.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic  valid_r [META_STAGES];
  meta_t meta_r  [META_STAGES];
  meta_t meta_nxt [META_STAGES];

  // Vertex coordinates and edge vectors; the user must keep them static while items are in flight (not enforced here).
  logic signed [VTX_W-1:0] vx [3];
  logic signed [VTX_W-1:0] vy [3];
  logic signed [FD_W-1:0]  fdx [3];
  logic signed [FD_W-1:0]  fdy [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      vx[v] = pos_r[v][15:0];
      vy[v] = pos_r[v][31:16];
    end
    for (int k = 0; k < 3; k++) begin
      fdx[k] = {vx[EDGE_TO[k]][VTX_W-1], vx[EDGE_TO[k]]}
             - {vx[EDGE_FROM[k]][VTX_W-1], vx[EDGE_FROM[k]]};
      fdy[k] = {vy[EDGE_TO[k]][VTX_W-1], vy[EDGE_TO[k]]}
             - {vy[EDGE_FROM[k]][VTX_W-1], vy[EDGE_FROM[k]]};
    end
  end

  // Stage 1: pixel center and its offsets from each edge start.
  logic [PIX_W-1:0]        in_col, in_row;
  logic signed [CRD_W-1:0] px, py;
  logic signed [GD_W-1:0]  gdx_r [3];
  logic signed [GD_W-1:0]  gdy_r [3];

  assign in_col = in_tdata[8:0];
  assign in_row = in_tdata[17:9];
  assign px = {7'b0, in_col, 4'b1000};
  assign py = CRD_W'(PY_BASE) - {7'b0, in_row, 4'b0000};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        gdx_r[k] <= {px[CRD_W-1], px}
                  - {{(GD_W-VTX_W){vx[EDGE_FROM[k]][VTX_W-1]}}, vx[EDGE_FROM[k]]};
        gdy_r[k] <= {py[CRD_W-1], py}
                  - {{(GD_W-VTX_W){vy[EDGE_FROM[k]][VTX_W-1]}}, vy[EDGE_FROM[k]]};
      end
    end
  end

  // Stage 2: cross products.
  logic signed [PRD_W-1:0] pa_r [3];
  logic signed [PRD_W-1:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k] <= gdx_r[k] * fdy[k];
        pb_r[k] <= gdy_r[k] * fdx[k];
      end
    end
  end

  // Stage 3: edge values.
  logic signed [EDG_W-1:0] w_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        w_r[k] <= {pa_r[k][PRD_W-1], pa_r[k]} - {pb_r[k][PRD_W-1], pb_r[k]};
      end
    end
  end

  // Stage 4: edge weights times vertex attributes. A negative weight only
  // matters for uncovered pixels, whose texels are forced to zero.
  logic covered_s3;
  logic [PRD_W+IZ_W-1:0] miz_r [3];
  logic [PRD_W+UZ_W-1:0] muz_r [3];
  logic [PRD_W+UZ_W-1:0] mvz_r [3];

  assign covered_s3 = !w_r[0][EDG_W-1] && !w_r[1][EDG_W-1] && !w_r[2][EDG_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        miz_r[k] <= w_r[k][PRD_W-1:0] * attr_r[k][23:0];
        muz_r[k] <= w_r[k][PRD_W-1:0] * attr_r[k][43:24];
        mvz_r[k] <= w_r[k][PRD_W-1:0] * attr_r[k][63:44];
      end
    end
  end

  // Stage 5: weighted sums.
  logic [SUM_W-1:0] den_r, nu_r, nv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= SUM_W'(miz_r[0]) + SUM_W'(miz_r[1]) + SUM_W'(miz_r[2]);
      nu_r  <= SUM_W'(muz_r[0]) + SUM_W'(muz_r[1]) + SUM_W'(muz_r[2]);
      nv_r  <= SUM_W'(mvz_r[0]) + SUM_W'(mvz_r[1]) + SUM_W'(mvz_r[2]);
    end
  end

  // Stage 6: numerator times 8 * (2 * size - 1), in two halves.
  logic [SCL_W-1:0]  scl_u, scl_v;
  logic [PART_W-1:0] ulo_r, uhi_r, vlo_r, vhi_r;
  logic [SUM_W-1:0]  den6_r;

  assign scl_u = {size_u, 4'b0000} - SCL_W'(8);
  assign scl_v = {size_v, 4'b0000} - SCL_W'(8);

  always_ff @(posedge clk) begin
    if (en) begin
      ulo_r  <= nu_r[31:0] * scl_u;
      uhi_r  <= nu_r[63:32] * scl_u;
      vlo_r  <= nv_r[31:0] * scl_v;
      vhi_r  <= nv_r[63:32] * scl_v;
      den6_r <= den_r;
    end
  end

  // Stage 7: full scaled numerators.
  logic [NUM_W-1:0] nnu_r, nnv_r;
  logic [SUM_W-1:0] den7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nnu_r  <= {uhi_r, 32'b0} + NUM_W'(ulo_r);
      nnv_r  <= {vhi_r, 32'b0} + NUM_W'(vlo_r);
      den7_r <= den6_r;
    end
  end

  // Stage 8: saturation and zero checks, then into the dividers.
  logic [NUM_W-1:0] nnu8_r, nnv8_r;
  logic [SUM_W-1:0] den8_r;
  logic             sat_u, sat_v, zero_u, zero_v;

  assign sat_u  = nnu_r[NUM_W-1:TEX_W] >= (NUM_W-TEX_W)'(den7_r);
  assign sat_v  = nnv_r[NUM_W-1:TEX_W] >= (NUM_W-TEX_W)'(den7_r);
  assign zero_u = (size_u == '0) || (den7_r == '0);
  assign zero_v = (size_v == '0) || (den7_r == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      nnu8_r <= nnu_r;
      nnv8_r <= nnv_r;
      den8_r <= den7_r;
    end
  end

  // Side data that travels with each pixel.
  always_comb begin
    meta_nxt[0] = '{col: in_col, row: in_row, cov: 1'b0, zero_u: 1'b0,
                    sat_u: 1'b0, zero_v: 1'b0, sat_v: 1'b0};
    for (int i = 1; i < META_STAGES; i++) begin
      meta_nxt[i] = meta_r[i-1];
    end
    meta_nxt[3].cov = covered_s3;
    meta_nxt[FRONT_STAGES-1].zero_u = zero_u;
    meta_nxt[FRONT_STAGES-1].sat_u  = sat_u;
    meta_nxt[FRONT_STAGES-1].zero_v = zero_v;
    meta_nxt[FRONT_STAGES-1].sat_v  = sat_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < META_STAGES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_tvalid;
      for (int i = 1; i < META_STAGES; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < META_STAGES; i++) begin
        meta_r[i] <= meta_nxt[i];
      end
    end
  end

  logic [TEX_W-1:0] quo_u, quo_v;

  tptc_div u_div_u (
    .clk   (clk),
    .en    (en),
    .num_i (nnu8_r),
    .den_i (den8_r),
    .quo_o (quo_u)
  );

  tptc_div u_div_v (
    .clk   (clk),
    .en    (en),
    .num_i (nnv8_r),
    .den_i (den8_r),
    .quo_o (quo_v)
  );

  // Output stage: select the texel by mode; perspective texels are clamped into the texture.
  meta_t            fin;
  logic [TEX_W-1:0] lim_u, lim_v, tu, tv, tx_nxt, ty_nxt;
  logic [47:0]      out_data_r;

  assign fin   = meta_r[META_STAGES-1];
  assign lim_u = size_u - TEX_W'(1);
  assign lim_v = size_v - TEX_W'(1);

  always_comb begin
    if (fin.zero_u) begin
      tu = '0;
    end else if (fin.sat_u || quo_u > lim_u) begin
      tu = lim_u;
    end else begin
      tu = quo_u;
    end
    if (fin.zero_v) begin
      tv = '0;
    end else if (fin.sat_v || quo_v > lim_v) begin
      tv = lim_v;
    end else begin
      tv = quo_v;
    end
    tx_nxt = '0;
    ty_nxt = '0;
    if (fin.cov) begin
      unique case (mode_r)
        MODE_PIXEL: begin
          tx_nxt = TEX_W'(fin.col);
          ty_nxt = TEX_W'(fin.row);
        end
        MODE_PERSP: begin
          tx_nxt = tu;
          ty_nxt = tv;
        end
        default: begin
          tx_nxt = '0;
          ty_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[META_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {3'b000, fin.row, fin.col, ty_nxt, tx_nxt, fin.cov};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/tptc_checker.sv
`include "triangle_pixel_texture_coord_assert.svh"

module tptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A held result word keeps its contents.
  `TPTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The pipeline takes a pixel exactly when its output slot can move.
  `TPTC_ASSERT_NOW(a_ready_follows, clk, rst_n, 1'b1, in_tready == (!out_tvalid || out_tready))

  // An uncovered pixel never names a texel.
  `TPTC_ASSERT_NOW(a_uncovered_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[26:1] == 26'd0)

  // With the output stalled, no new pixel is taken.
  `TPTC_ASSERT_NOW(a_no_take_on_stall, clk, rst_n, out_tvalid && !out_tready, !(in_tvalid && in_tready))

endmodule

bind triangle_pixel_texture_coord tptc_checker u_tptc_checker (.*);
